// ===== src/vdc_pkg.sv =====
// vdc_pkg: types, widths and codes for the vector distance / cosine block
// used by every module under src
`timescale 1ns / 1ps
package vdc_pkg;

  localparam int COORD_BITS       = 16;
  localparam int COSINE_FRAC_BITS = 14;
  localparam int MAG_EXTRA        = 15;
  localparam int FIFO_DEPTH       = 2;

  localparam int DIST_W  = 17;
  localparam int COS_W   = 16;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SUM_W   = 2 * DIFF_W;
  localparam int MAG_W   = 2 * COORD_BITS;
  localparam int DOT_W   = 2 * COORD_BITS + 1;
  localparam int NUM_W   = 2 * COORD_BITS;
  localparam int SQ_IN_W = MAG_W + 2 * MAG_EXTRA;
  localparam int ROOT_W  = SQ_IN_W / 2;
  localparam int DEN_W   = 2 * ROOT_W;
  localparam int REM_W   = DEN_W + 2;
  localparam int Q_W     = COSINE_FRAC_BITS + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [Q_W-1:0]    COS_CAP  = Q_W'(1) << COSINE_FRAC_BITS;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_COS   = 2'd1,
    ST_ZERO_MAG = 2'd2
  } status_e;

  typedef struct packed {
    logic                         action;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]       distance;
    logic signed [COS_W-1:0] cosine;
    status_e                 status;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                    three_d;
    logic [SUM_W-1:0]        sum;
    logic [MAG_W-1:0]        m1;
    logic [MAG_W-1:0]        m2;
    logic signed [DOT_W-1:0] dot;
  } front_item_t;

  typedef struct packed {
    logic             three_d;
    logic             zero;
    logic             neg;
    logic [NUM_W-1:0] num;
  } sq_side_t;

  typedef struct packed {
    logic              three_d;
    logic              zero;
    logic              neg;
    logic [DIST_W-1:0] euclid;
  } div_side_t;

endpackage

// ===== src/vdc_front.sv =====
// vdc_front: accepts point pairs, forms differences, squares and dot product
// depends on vdc_pkg
`timescale 1ns / 1ps
module vdc_front import vdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  input  logic        full_i,
  output logic        push_o,
  output front_item_t entry_o
);

  logic                         vld_q, vld_d;
  logic                         three_d_q;
  logic        [DIFF_W-1:0]     dx_q, dy_q, dz_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [DIFF_W-1:0]     dxs, dys, dzs;
  logic        [SUM_W-1:0]      sqx, sqy, sqz;
  logic signed [MAG_W-1:0]      pxx, pyy, qxx, qyy, pxb, pyb;

  assign in_ready_o = !vld_q || !full_i;
  assign push_o     = vld_q && !full_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  assign dxs = $signed({in_data_i.second_x[COORD_BITS-1], in_data_i.second_x})
             - $signed({in_data_i.first_x[COORD_BITS-1], in_data_i.first_x});
  assign dys = $signed({in_data_i.second_y[COORD_BITS-1], in_data_i.second_y})
             - $signed({in_data_i.first_y[COORD_BITS-1], in_data_i.first_y});
  assign dzs = $signed({in_data_i.second_z[COORD_BITS-1], in_data_i.second_z})
             - $signed({in_data_i.first_z[COORD_BITS-1], in_data_i.first_z});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      three_d_q <= in_data_i.action;
      dx_q      <= dxs[DIFF_W-1] ? $unsigned(-dxs) : $unsigned(dxs);
      dy_q      <= dys[DIFF_W-1] ? $unsigned(-dys) : $unsigned(dys);
      dz_q      <= dzs[DIFF_W-1] ? $unsigned(-dzs) : $unsigned(dzs);
      ax_q      <= in_data_i.first_x;
      ay_q      <= in_data_i.first_y;
      bx_q      <= in_data_i.second_x;
      by_q      <= in_data_i.second_y;
    end
  end

  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  assign sqz = three_d_q ? dz_q * dz_q : '0;
  assign pxx = ax_q * ax_q;
  assign pyy = ay_q * ay_q;
  assign qxx = bx_q * bx_q;
  assign qyy = by_q * by_q;
  assign pxb = ax_q * bx_q;
  assign pyb = ay_q * by_q;

  always_comb begin
    entry_o.three_d = three_d_q;
    entry_o.sum     = sqx + sqy + sqz;
    entry_o.m1      = $unsigned(pxx) + $unsigned(pyy);
    entry_o.m2      = $unsigned(qxx) + $unsigned(qyy);
    entry_o.dot     = DOT_W'(pxb) + DOT_W'(pyb);
  end

endmodule

// ===== src/vdc_fifo.sv =====
// vdc_fifo: short register queue between front and back
// depends on vdc_pkg
`timescale 1ns / 1ps
module vdc_fifo import vdc_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  front_item_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output front_item_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  front_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/vdc_isqrt.sv =====
// vdc_isqrt: pipelined integer square root, one root bit per stage
// depends on vdc_pkg
`timescale 1ns / 1ps
module vdc_isqrt import vdc_pkg::*; #(
  parameter int IN_W = SQ_IN_W
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IN_W-1:0]     radicand_i,
  output logic [IN_W/2-1:0]   root_o
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] v_q    [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [IN_W-1:0] v_in;
    logic [RW+1:0]   rem_in, sh, trial;
    logic [RW-1:0]   root_in;
    logic            ge;

    if (s == 0) begin : g_first
      assign v_in    = radicand_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign sh    = {rem_in[RW-1:0], v_in[IN_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s]    <= v_in << 2;
        rem_q[s]  <= ge ? sh - trial : sh;
        root_q[s] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== src/vdc_div.sv =====
// vdc_div: pipelined restoring divider, one quotient bit per stage
// depends on vdc_pkg
`timescale 1ns / 1ps
module vdc_div import vdc_pkg::*; #(
  parameter int D_W  = DEN_W,
  parameter int QB_W = Q_W
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [D_W+1:0]  rem_i,
  input  logic [D_W-1:0]  den_i,
  output logic [QB_W-1:0] quot_o
);

  logic [D_W+1:0]  r_q [QB_W];
  logic [D_W-1:0]  d_q [QB_W];
  logic [QB_W-1:0] q_q [QB_W];

  for (genvar s = 0; s < QB_W; s++) begin : g_stage
    logic [D_W+1:0]  r_in, r_sub;
    logic [D_W-1:0]  d_in;
    logic [QB_W-1:0] q_in;
    logic            ge;

    if (s == 0) begin : g_first
      assign r_in = rem_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
      assign q_in = q_q[s-1];
    end

    assign ge    = r_in >= {2'b00, d_in};
    assign r_sub = ge ? r_in - {2'b00, d_in} : r_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_sub << 1;
        d_q[s] <= d_in;
        q_q[s] <= {q_in[QB_W-2:0], ge};
      end
    end
  end

  assign quot_o = q_q[QB_W-1];

endmodule

// ===== src/vdc_back.sv =====
// vdc_back: square roots, magnitude product, cosine division, output register
// depends on vdc_pkg, vdc_isqrt, vdc_div
`timescale 1ns / 1ps
module vdc_back import vdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  front_item_t entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic                adv;
  logic [ROOT_W:0]     v1_q;
  sq_side_t            s1_q [ROOT_W+1];
  logic [Q_W:0]        v2_q;
  div_side_t           s2_q [Q_W+1];
  logic [SQ_IN_W-1:0]  rad_d_q, rad_1_q, rad_2_q;
  logic [ROOT_W-1:0]   root_d, root_1, root_2;
  logic [DEN_W-1:0]    den_q;
  logic [REM_W-1:0]    rem0_q;
  logic [Q_W-1:0]      quot;
  logic [Q_W-1:0]      cmag;
  logic                out_valid_q;
  out_item_t           out_data_q;
  sq_side_t            side0;

  // whole back pipeline moves together, held only by a stalled output
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    side0.three_d = entry_i.three_d;
    side0.zero    = (entry_i.m1 == '0) || (entry_i.m2 == '0);
    side0.neg     = entry_i.dot[DOT_W-1];
    side0.num     = NUM_W'(entry_i.dot[DOT_W-1] ? $unsigned(-entry_i.dot)
                                                 : $unsigned(entry_i.dot));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= '0;
      v2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= {v1_q[ROOT_W-1:0], !empty_i};
      v2_q        <= {v2_q[Q_W-1:0], v1_q[ROOT_W]};
      out_valid_q <= v2_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_d_q <= SQ_IN_W'(entry_i.sum);
      rad_1_q <= {entry_i.m1, (2 * MAG_EXTRA)'(0)};
      rad_2_q <= {entry_i.m2, (2 * MAG_EXTRA)'(0)};
      s1_q[0] <= side0;
      for (int i = 1; i <= ROOT_W; i++) begin
        s1_q[i] <= s1_q[i-1];
      end
      den_q           <= root_1 * root_2;
      rem0_q          <= REM_W'(s1_q[ROOT_W].num) << (2 * MAG_EXTRA);
      s2_q[0].three_d <= s1_q[ROOT_W].three_d;
      s2_q[0].zero    <= s1_q[ROOT_W].zero;
      s2_q[0].neg     <= s1_q[ROOT_W].neg;
      s2_q[0].euclid  <= (root_d > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_d);
      for (int i = 1; i <= Q_W; i++) begin
        s2_q[i] <= s2_q[i-1];
      end
      out_data_q <= '{distance: s2_q[Q_W].euclid,
                      cosine:   (s2_q[Q_W].three_d || s2_q[Q_W].zero) ? '0 :
                                s2_q[Q_W].neg ? -$signed(COS_W'(cmag))
                                              :  $signed(COS_W'(cmag)),
                      status:   s2_q[Q_W].three_d ? ST_NO_COS :
                                s2_q[Q_W].zero    ? ST_ZERO_MAG : ST_OK};
    end
  end

  vdc_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_dist (
    .clk_i, .en_i(adv), .radicand_i(rad_d_q), .root_o(root_d)
  );
  vdc_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_mag1 (
    .clk_i, .en_i(adv), .radicand_i(rad_1_q), .root_o(root_1)
  );
  vdc_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_mag2 (
    .clk_i, .en_i(adv), .radicand_i(rad_2_q), .root_o(root_2)
  );

  vdc_div #(.D_W(DEN_W), .QB_W(Q_W)) u_div (
    .clk_i, .en_i(adv), .rem_i(rem0_q), .den_i(den_q), .quot_o(quot)
  );

  // top quotient bit means the ratio reached one
  assign cmag = quot[Q_W-1] ? COS_CAP : quot;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/vector_distance_cosine.sv =====
// vector_distance_cosine: Euclidean distance and 2D cosine similarity
// depends on vdc_pkg, vdc_front, vdc_fifo, vdc_back
//
// Usage: the input channel (in_valid_i / in_ready_o / in_data_i) takes one
// point pair per transfer with a 2D/3D mode bit. The output channel
// (out_valid_o / out_ready_i / out_data_o) returns one result per pair, in
// order: distance as an unsigned Q17.0 integer, cosine in Q1.14 and a status code.
// From input transfer to output valid an item passes, in order, through
// one front register, one queue slot, one issue register, 31 square-root
// stages, one magnitude multiply, 15 divider stages and the output register.
// Throughput is one pair per cycle while the output is not stalled; every
// stage of the square roots and the divider holds one item.
// When the receiver stalls the whole back pipeline holds, the queue of
// FIFO_DEPTH entries fills, then the front register, and in_ready_o drops.
// Reset clears all valid flags and queue pointers; no item is in flight after
// reset and no clearing pass is needed.
`timescale 1ns / 1ps
module vector_distance_cosine import vdc_pkg::*; #(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic        push, pop, full, empty;
  front_item_t push_data, pop_data;

  vdc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .full_i(full), .push_o(push), .entry_o(push_data)
  );

  vdc_fifo #(.DEPTH(FIFO_DEPTH_P)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(pop_data)
  );

  vdc_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_no_cos_3d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_NO_COS |-> out_data_o.cosine == '0)
    else $error("3D result carries a cosine");

  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_ZERO_MAG |-> out_data_o.cosine == '0)
    else $error("zero magnitude result carries a cosine");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cosine <= $signed(COS_W'(COS_CAP)) &&
                    out_data_o.cosine >= -$signed(COS_W'(COS_CAP)))
    else $error("cosine beyond one");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result lost");

  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule
